>>> hw/rtl/swmf_pkg.sv
// Shared types and constants for the sliding window median filter.
// No dependencies.
package swmf_pkg;
    localparam int ORDER_MAX_DEF    = 16;
    localparam int CHANNELS_DEF     = 8;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int CFG_WIDTH        = 5;
    localparam int REG_ORDER_W      = 5;
    localparam int REG_CHANS_W      = 4;
    localparam int CHANNEL_W        = 3;

    typedef enum logic [0:0] {
        REG_WINDOW_ORDER    = 1'b0,
        REG_CHANNELS_IN_USE = 1'b1
    } reg_index_t;
endpackage

>>> hw/rtl/sliding_window_median_filter_top.sv
// Top level of the sliding window median filter: control sequencer around the window memory.
// Uses swmf_pkg and swmf_window_ram.
//
// Usage:
// - Input channel s_*: one item is one channel element of a frame (sample, invalid flag,
//   channel index, frame_end). Result channel m_*: median, channel, frame_end.
// - Configuration: write cfg_we with cfg_index/cfg_data while idle. Writing window_order
//   clears all windows; this runs a clearing pass over the CHANNELS*ORDER_MAX entries (128
//   at the defaults) during which no item is accepted. Reset runs the same pass.
// - Each item on a channel in use writes its sample into the channel's window; after warmup
//   it then ranks window entries against the whole window. The window memory has one read
//   port, so entries are ranked one at a time and each rank pass reads the whole window.
//   The scan stops once the needed ranks are found; the next item is accepted only after
//   the scan ends and the result moves to the output register.
// - Items that give no result (warmup, channel out of use) do not hold up the next item.
// - A finished result sits in the output register; the next item is accepted while it
//   waits, and the block stalls only when a second result is ready before the first is
//   taken.
// - Reset (aresetn low, synchronous) clears control state and starts the clearing pass.
module sliding_window_median_filter_top
    import swmf_pkg::*;
#(
    parameter int ORDER_MAX    = ORDER_MAX_DEF,
    parameter int CHANNELS     = CHANNELS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_index,
    input  logic [CFG_WIDTH-1:0]    cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    input  logic                    s_sample_invalid,
    input  logic [CHANNEL_W-1:0]    s_channel,
    input  logic                    s_frame_end,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_median,
    output logic [CHANNEL_W-1:0]    m_out_channel,
    output logic                    m_out_frame_end
);
    localparam int DEPTH = CHANNELS * ORDER_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = $clog2(ORDER_MAX + 1);
    localparam int PW    = (ORDER_MAX > 1) ? $clog2(ORDER_MAX) : 1;
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int W     = SAMPLE_WIDTH;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_OUTER  = 7'b0000100,
        ST_IWAIT  = 7'b0001000,
        ST_INNER  = 7'b0010000,
        ST_CHECK  = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [REG_ORDER_W-1:0] order_cfg_reg;
    logic [REG_CHANS_W-1:0] chans_cfg_reg;
    logic [AW:0]  clr_reg;
    logic [PW-1:0] wpos_reg;
    logic [PW-1:0] warm_reg;
    logic [OW-1:0] ord;
    logic [OW-1:0] chans_n;
    logic [PW-1:0] delay;

    // item registers
    logic [W-1:0]  val_reg;
    logic [CW-1:0] ch_reg;
    logic [CHANNEL_W-1:0] och_reg;
    logic          fe_reg;
    logic [OW-1:0] i_reg, j_reg;
    logic [W-1:0]  ki_reg;
    logic [OW-1:0] lt_reg, le_reg;
    logic          got_lo_reg, got_hi_reg;
    logic [W-1:0]  lo_reg, hi_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [W-1:0]  wr_data, rd_data;

    // effective order and channel count
    always_comb begin
        if (order_cfg_reg == '0) ord = OW'(1);
        else if (32'(order_cfg_reg) > ORDER_MAX) ord = OW'(ORDER_MAX);
        else ord = OW'(order_cfg_reg);
        if (chans_cfg_reg == '0) chans_n = OW'(1);
        else if (32'(chans_cfg_reg) > CHANNELS) chans_n = OW'(CHANNELS);
        else chans_n = OW'(chans_cfg_reg);
    end
    logic [OW-1:0] ord_m1;
    assign ord_m1 = ord - OW'(1);
    assign delay  = PW'(ord_m1 >> 1);

    logic [PW-1:0] wpos_eff;
    assign wpos_eff = (OW'(wpos_reg) >= ord) ? '0 : wpos_reg;

    logic in_use;
    assign in_use = (OW'(s_channel) < chans_n) && (32'(s_channel) < CHANNELS);
    logic out_free;
    assign out_free = !m_valid || m_ready;
    assign s_ready = (state_reg == ST_IDLE) && aresetn;

    logic acc;
    assign acc = s_valid && s_ready;

    // an order write restarts the windows
    logic order_wr;
    assign order_wr = cfg_we && (cfg_index == REG_WINDOW_ORDER);

    logic [AW-1:0] base;
    assign base = AW'(32'(ch_reg) * ORDER_MAX);

    swmf_window_ram #(.DEPTH(DEPTH), .WIDTH(W)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // write: clearing pass or new sample
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = AW'(clr_reg);
        wr_data = '0;
        if (state_reg == ST_CLEAR) begin
            wr_en = 1'b1;
        end else if (acc && in_use) begin
            wr_en   = 1'b1;
            wr_addr = AW'(32'(s_channel) * ORDER_MAX) + AW'(wpos_eff);
            wr_data = s_sample_invalid ? '0 : s_sample;
        end
    end

    // read address: outer entry in ST_OUTER, inner entry in all other states
    always_comb begin
        if (state_reg == ST_OUTER) rd_addr = base + AW'(i_reg);
        else rd_addr = base + AW'(j_reg);
    end

    logic [W-1:0] kj_sw, ki_sw;
    assign kj_sw = rd_data ^ {1'b1, {(W-1){1'b0}}};
    assign ki_sw = ki_reg  ^ {1'b1, {(W-1){1'b0}}};

    logic [OW-1:0] lt_n, le_n;
    assign lt_n = lt_reg + OW'(kj_sw <  ki_sw);
    assign le_n = le_reg + OW'(kj_sw <= ki_sw);

    logic [OW-1:0] k_lo, k_hi;
    assign k_lo = OW'(delay);
    assign k_hi = OW'(delay) + OW'(1);
    logic hit_lo, hit_hi, even;
    assign hit_lo = (lt_reg <= k_lo) && (k_lo < le_reg);
    assign hit_hi = (lt_reg <= k_hi) && (k_hi < le_reg);
    assign even   = !ord[0];

    logic [W-1:0] med;
    always_comb begin
        med = lo_reg;
        if (even) begin
            med = {lo_reg[W-1], lo_reg[W-1:1]} + {hi_reg[W-1], hi_reg[W-1:1]}
                + W'(lo_reg[0] & hi_reg[0]);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == (AW+1)'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (acc && in_use && warm_reg >= delay) state_next = ST_OUTER;
            end
            ST_OUTER: state_next = ST_IWAIT;
            ST_IWAIT: state_next = ST_INNER;
            // read data lags the inner index by one: the last entry arrives at j == ord
            ST_INNER: if (j_reg == ord) state_next = ST_CHECK;
            ST_CHECK: begin
                // stop once both ranks (or the one needed) are found
                if ((got_lo_reg || hit_lo) && (!even || got_hi_reg || hit_hi))
                    state_next = ST_EMIT;
                else if (i_reg == ord_m1) state_next = ST_EMIT;
                else state_next = ST_OUTER;
            end
            ST_EMIT: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_CLEAR;
        endcase
        if (order_wr) state_next = ST_CLEAR;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            order_cfg_reg <= REG_ORDER_W'(5);
            chans_cfg_reg <= REG_CHANS_W'(1);
            clr_reg       <= '0;
            wpos_reg      <= '0;
            warm_reg      <= '0;
            m_valid       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (order_wr) clr_reg <= '0;
            else if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_WINDOW_ORDER: order_cfg_reg <= cfg_data[REG_ORDER_W-1:0];
                    REG_CHANNELS_IN_USE: chans_cfg_reg <= cfg_data[REG_CHANS_W-1:0];
                    default: ;
                endcase
            end
            if (order_wr) begin
                wpos_reg <= '0;
                warm_reg <= '0;
            end else if (acc) begin
                if (s_frame_end) begin
                    wpos_reg <= (OW'(wpos_eff) + OW'(1) >= ord) ? '0 : wpos_eff + 1'b1;
                    if (warm_reg < delay) warm_reg <= warm_reg + 1'b1;
                end else begin
                    wpos_reg <= wpos_eff;
                end
            end
            if (state_reg == ST_EMIT && out_free) m_valid <= 1'b1;
            else if (m_valid && m_ready) m_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (acc) begin
            ch_reg     <= CW'(s_channel);
            och_reg    <= s_channel;
            fe_reg     <= s_frame_end;
            i_reg      <= '0;
            got_lo_reg <= 1'b0;
            got_hi_reg <= 1'b0;
        end
        if (state_reg == ST_OUTER) begin
            j_reg  <= '0;
            lt_reg <= '0;
            le_reg <= '0;
        end
        if (state_reg == ST_IWAIT) begin
            ki_reg <= rd_data;
            j_reg  <= j_reg + 1'b1;
        end
        if (state_reg == ST_INNER) begin
            lt_reg <= lt_n;
            le_reg <= le_n;
            if (j_reg != ord) j_reg <= j_reg + 1'b1;
        end
        if (state_reg == ST_CHECK) begin
            i_reg <= i_reg + 1'b1;
            if (hit_lo && !got_lo_reg) begin
                lo_reg <= ki_reg;
                got_lo_reg <= 1'b1;
            end
            if (hit_hi && !got_hi_reg) begin
                hi_reg <= ki_reg;
                got_hi_reg <= 1'b1;
            end
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_median        <= med;
            m_out_channel   <= och_reg;
            m_out_frame_end <= fe_reg;
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_no_acc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready) else $error("accept during clear");
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && !order_wr)
        |=> m_valid) else $error("result lost");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHECK |-> le_reg <= ord && lt_reg <= le_reg)
        else $error("rank counts out of range");
endmodule

>>> hw/rtl/swmf_window_ram.sv
// Window storage: one synchronous memory, one write port, one registered read port.
// Uses swmf_pkg.
module swmf_window_ram
    import swmf_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

>>> sim/swmf_median_checker.sv
// Checker for the sliding window median filter: watches both channels and the config port,
// predicts each median from its own copy of the windows and compares field by field.
// Depends on swmf_pkg.
module swmf_median_checker
    import swmf_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [CFG_WIDTH-1:0]        cfg_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic signed [31:0]          s_sample,
    input  logic                        s_sample_invalid,
    input  logic [CHANNEL_W-1:0]        s_channel,
    input  logic                        s_frame_end,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic signed [31:0]          m_median,
    input  logic [CHANNEL_W-1:0]        m_out_channel,
    input  logic                        m_out_frame_end,
    output int                          pending,
    output int                          failures
);
    typedef struct {
        logic signed [31:0]   median;
        logic [CHANNEL_W-1:0] chan;
        logic                 fe;
    } median_exp_t;

    median_exp_t          medians_due[$];
    logic signed [31:0]   windows [CHANNELS_DEF][ORDER_MAX_DEF];
    logic [REG_ORDER_W-1:0] order_reg;
    logic [REG_CHANS_W-1:0] chans_reg;
    int                   slot;
    int                   frames_done;

    assign pending = medians_due.size();

    task automatic clear_windows();
        foreach (windows[c, i]) windows[c][i] = '0;
        slot = 0;
        frames_done = 0;
    endtask

    task automatic predict_median(logic signed [31:0] smp, logic inv,
                                  logic [CHANNEL_W-1:0] ch, logic fe);
        int ord;
        int nch;
        int delay;
        logic signed [31:0] sorted [ORDER_MAX_DEF];
        logic signed [31:0] key;
        logic signed [32:0] sum;
        median_exp_t e;
        int j;
        ord = (order_reg == 0) ? 1 : (order_reg > ORDER_MAX_DEF) ? ORDER_MAX_DEF : order_reg;
        nch = (chans_reg == 0) ? 1 : (chans_reg > CHANNELS_DEF) ? CHANNELS_DEF : chans_reg;
        delay = (ord - 1) / 2;
        if (slot >= ord) slot = 0;
        if (ch < nch) begin
            windows[ch][slot] = inv ? 32'sd0 : smp;
            if (frames_done >= delay) begin
                // insertion sort of the live part of the window
                for (int i = 0; i < ord; i++) begin
                    key = windows[ch][i];
                    j = i - 1;
                    while (j >= 0 && sorted[j] > key) begin
                        sorted[j + 1] = sorted[j];
                        j--;
                    end
                    sorted[j + 1] = key;
                end
                if (ord % 2 == 0) begin
                    sum = {sorted[delay][31], sorted[delay]}
                        + {sorted[delay + 1][31], sorted[delay + 1]};
                    e.median = sum[32:1];
                end else begin
                    e.median = sorted[delay];
                end
                e.chan = ch;
                e.fe = fe;
                medians_due.insert(medians_due.size(), e);
            end
        end
        if (fe) begin
            slot = (slot + 1 >= ord) ? 0 : slot + 1;
            if (frames_done < delay) frames_done++;
        end
    endtask

    initial failures = 0;

    always @(posedge aclk) begin
        median_exp_t e;
        if (!aresetn) begin
            clear_windows();
            order_reg = REG_ORDER_W'(5);
            chans_reg = REG_CHANS_W'(1);
            medians_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (medians_due.size() == 0) begin
                    $error("unexpected result: median %0d channel %0d",
                           m_median, m_out_channel);
                    failures++;
                end else begin
                    e = medians_due.pop_front();
                    if (m_median !== e.median) begin
                        $error("median: expected %0d actual %0d", e.median, m_median);
                        failures++;
                    end
                    if (m_out_channel !== e.chan) begin
                        $error("out_channel: expected %0d actual %0d", e.chan, m_out_channel);
                        failures++;
                    end
                    if (m_out_frame_end !== e.fe) begin
                        $error("out_frame_end: expected %0d actual %0d",
                               e.fe, m_out_frame_end);
                        failures++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == REG_WINDOW_ORDER) begin
                    order_reg = cfg_data[REG_ORDER_W-1:0];
                    clear_windows();
                end else begin
                    chans_reg = cfg_data[REG_CHANS_W-1:0];
                end
            end
            if (s_valid && s_ready)
                predict_median(s_sample, s_sample_invalid, s_channel, s_frame_end);
        end
    end
endmodule

>>> sim/sliding_window_median_filter_top_test.sv
// Testbench top for the sliding window median filter: clock, reset, stimulus and verdict.
// Depends on swmf_pkg, sliding_window_median_filter_top and swmf_median_checker.
module sliding_window_median_filter_top_test;
    import swmf_pkg::*;

    localparam int IDLE_LIMIT = 20000;  // cycles with no item moving
    localparam int DRAIN_WAIT = 400;    // longest item (at order 16) plus margin

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [0:0]             cfg_index = REG_WINDOW_ORDER;
    logic [CFG_WIDTH-1:0]   cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [31:0]     s_sample = '0;
    logic                   s_sample_invalid = 1'b0;
    logic [CHANNEL_W-1:0]   s_channel = '0;
    logic                   s_frame_end = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic signed [31:0]     m_median;
    logic [CHANNEL_W-1:0]   m_out_channel;
    logic                   m_out_frame_end;
    int                     pending;
    int                     failures;
    bit                     quiet = 1'b0;   // no idling in the last part of the run
    int                     stall_left = 0;
    int                     idle_cycles = 0;

    // phase table: window order, channels in use, item count
    int phase_order [12] = '{2, 3, 1, 0, 4, 16, 7, 31, 6, 8, 5, 3};
    int phase_chans [12] = '{2, 3, 8, 1, 15, 2, 4, 1, 0, 8, 5, 6};
    int phase_items [12] = '{150, 150, 140, 120, 150, 40, 150, 30, 150, 150, 150, 150};

    always #10 aclk = ~aclk;

    sliding_window_median_filter_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .s_sample_invalid(s_sample_invalid), .s_channel(s_channel),
        .s_frame_end(s_frame_end),
        .m_valid(m_valid), .m_ready(m_ready), .m_median(m_median),
        .m_out_channel(m_out_channel), .m_out_frame_end(m_out_frame_end)
    );

    swmf_median_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .s_sample_invalid(s_sample_invalid), .s_channel(s_channel),
        .s_frame_end(s_frame_end),
        .m_valid(m_valid), .m_ready(m_ready), .m_median(m_median),
        .m_out_channel(m_out_channel), .m_out_frame_end(m_out_frame_end),
        .pending(pending), .failures(failures)
    );

    // Result side: stall in random bursts, hold ready high once quiet.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready = 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    // Watchdog: end the run if no item moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Pick a sample, biased toward extremes and small values so windows see ties.
    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2, 3: return $signed($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Drive one item and hold it until accepted; valid stays high afterwards.
    task automatic send_item(logic signed [31:0] smp, logic inv,
                             logic [CHANNEL_W-1:0] ch, logic fe);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_sample = smp;
        s_sample_invalid = inv;
        s_channel = ch;
        s_frame_end = fe;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drain all expected results, then let any resultless item finish.
    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, int value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value[CFG_WIDTH-1:0];
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    initial begin
        int nch;
        int sent;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Directed items under the reset settings (order 5, one channel).
        send_item(32'sh7fff_ffff, 1'b0, 3'd0, 1'b1);
        send_item(32'sh8000_0000, 1'b0, 3'd0, 1'b1);
        send_item(32'sh1234_5678, 1'b1, 3'd0, 1'b1);   // invalid counts as zero
        send_item(32'sh0000_0000, 1'b0, 3'd0, 1'b1);
        send_item(32'sh7fff_ffff, 1'b0, 3'd0, 1'b1);
        send_item(32'sh0001_0000, 1'b0, 3'd5, 1'b1);   // channel not in use, still ends frame
        send_item(-32'sh0001_0000, 1'b0, 3'd0, 1'b0);
        send_item(32'sh7fff_ffff, 1'b0, 3'd0, 1'b1);   // repeated channel overwrites its slot
        send_item(32'sh8000_0000, 1'b1, 3'd0, 1'b1);
        send_item(32'sh7fff_fffe, 1'b0, 3'd7, 1'b0);

        foreach (phase_order[p]) begin
            wait_idle();
            if (p == 11) quiet = 1'b1;
            write_reg(REG_WINDOW_ORDER, phase_order[p]);
            write_reg(REG_CHANNELS_IN_USE, phase_chans[p]);
            nch = (phase_chans[p] == 0) ? 1 : (phase_chans[p] > 8) ? 8 : phase_chans[p];
            sent = 0;
            while (sent < phase_items[p]) begin
                if ($urandom_range(0, 9) < 8) begin
                    // well-formed frame: each channel in use once, frame_end on the last
                    for (int c = 0; c < nch; c++)
                        send_item(pick_sample(), $urandom_range(0, 7) == 0, CHANNEL_W'(c),
                                  c == nch - 1);
                    sent += nch;
                end else begin
                    send_item(pick_sample(), 1'($urandom_range(0, 1)),
                              CHANNEL_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end

        wait_idle();
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

>>> files.f
hw/rtl/swmf_pkg.sv
hw/rtl/swmf_window_ram.sv
hw/rtl/sliding_window_median_filter_top.sv
sim/swmf_median_checker.sv
sim/sliding_window_median_filter_top_test.sv
